[rtl/core/fba_pkg.sv]
// Shared types, sizes and codes for the block allocator.
// No dependencies; every file of the block imports this package.
package fba_pkg;

    localparam int NUM_BLOCKS   = 128;
    localparam int ROOT_ENTRIES = 16;
    localparam int BLK_W        = 7;
    localparam int NAME_W       = 48;
    localparam int DIR_AW       = 4;
    localparam int STEP_W       = 8;

    localparam logic [BLK_W-1:0]  LAST_BLOCK = BLK_W'(NUM_BLOCKS - 1);
    localparam logic [BLK_W-1:0]  MIN_FIRST  = BLK_W'(2);
    localparam logic [BLK_W-1:0]  CFG_RESET  = BLK_W'(8);
    localparam logic [DIR_AW-1:0] LAST_ENTRY = DIR_AW'(ROOT_ENTRIES - 1);
    localparam logic [STEP_W-1:0] MAX_STEPS  = STEP_W'(NUM_BLOCKS);

    localparam logic [2:0] REQ_FORMAT = 3'd0;
    localparam logic [2:0] REQ_CREATE = 3'd1;
    localparam logic [2:0] REQ_LOOKUP = 3'd2;
    localparam logic [2:0] REQ_ADD    = 3'd3;
    localparam logic [2:0] REQ_REMOVE = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EXISTS    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NO_FREE   = 3'd4;
    localparam logic [2:0] ST_NOT_EMPTY = 3'd5;

    typedef struct packed {
        logic             we;
        logic [BLK_W-1:0] waddr;
        logic [BLK_W-1:0] wdata;
        logic [BLK_W-1:0] raddr;
    } t_link_req;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [BLK_W-1:0]  first;
    } t_dir_entry;

    typedef struct packed {
        logic              we;
        logic [DIR_AW-1:0] waddr;
        t_dir_entry        wdata;
        logic [DIR_AW-1:0] raddr;
    } t_dir_req;

endpackage

[rtl/core/fba_link_ram.sv]
// Link table memory: one next-block link per block, one write and one read port.
// Depends on fba_pkg.
module fba_link_ram (
    input  logic                     i_clk,
    input  fba_pkg::t_link_req       i_req,
    output logic [fba_pkg::BLK_W-1:0] o_rdata
);
    import fba_pkg::*;

    logic [BLK_W-1:0] r_mem [NUM_BLOCKS];
    logic [BLK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/fba_dir_ram.sv]
// Root directory memory holding each entry's name key and first block.
// Depends on fba_pkg; valid bits are kept in the top level.
module fba_dir_ram (
    input  logic                i_clk,
    input  fba_pkg::t_dir_req   i_req,
    output fba_pkg::t_dir_entry o_rdata
);
    import fba_pkg::*;

    t_dir_entry r_mem [ROOT_ENTRIES];
    t_dir_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/fat_block_allocator.sv]
// File allocation table with a free-block chain and a small root directory.
// Depends on fba_pkg, fba_link_ram and fba_dir_ram.
//
// Usage: a request beat arrives on the slave stream. Its tuser carries the
// request type (format, create, lookup, add block, remove) and its tdata the
// 48-bit name key. Each request yields exactly one result beat on the master
// stream: tuser holds the status code and tdata the block number.
// The first data block register is written over the cfg channel, which is
// always ready; write it only while no request is in flight.
// Requests are handled one at a time. A format sweeps the link table, one
// entry per cycle. Other requests first scan the 16 directory entries one by
// one, then an add pops the free head and may walk the file's chain through
// the link table memory, up to 128 links. Each directory entry and each link
// is read through the single registered read port of its memory.
// A result waits in an output register; while the receiver stalls, the next
// request is accepted and worked on, and holds only at its result.
// Reset clears the directory valid bits and the free head and loads 8 into
// the first data block register. The link table holds nothing until a format.
module fat_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,   // [6:0] first_data_block
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,    // [47:0] file_name
    input  logic [2:0]  i_s_tuser,    // [2:0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,    // [6:0] block
    output logic [2:0]  o_m_tuser     // [2:0] status
);
    import fba_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FMT    = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_SCAN_D = 4'd3;
    localparam logic [3:0] S_EXEC   = 4'd4;
    localparam logic [3:0] S_POP    = 4'd5;
    localparam logic [3:0] S_POP_D  = 4'd6;
    localparam logic [3:0] S_WALK   = 4'd7;
    localparam logic [3:0] S_WALK_D = 4'd8;
    localparam logic [3:0] S_RESP   = 4'd9;

    logic [3:0]              r_state, n_state;
    logic [BLK_W-1:0]        r_cfg;
    logic [2:0]              r_req, n_req;
    logic [NAME_W-1:0]       r_name, n_name;
    logic [DIR_AW-1:0]       r_idx, n_idx;
    logic                    r_hit, n_hit;
    logic [DIR_AW-1:0]       r_eidx, n_eidx;
    logic [BLK_W-1:0]        r_efirst, n_efirst;
    logic [BLK_W-1:0]        r_faddr, n_faddr;
    logic [BLK_W-1:0]        r_free_head, n_free_head;
    logic [ROOT_ENTRIES-1:0] r_valid, n_valid;
    logic [BLK_W-1:0]        r_alloc, n_alloc;
    logic [BLK_W-1:0]        r_cur, n_cur;
    logic [STEP_W-1:0]       r_steps, n_steps;
    logic [2:0]              r_status, n_status;
    logic [BLK_W-1:0]        r_block, n_block;
    logic                    r_out_valid, n_out_valid;
    logic [2:0]              r_out_status, n_out_status;
    logic [BLK_W-1:0]        r_out_block, n_out_block;

    t_link_req        link_req;
    logic [BLK_W-1:0] link_rdata;
    t_dir_req         dir_req;
    t_dir_entry       dir_rdata;

    logic [BLK_W-1:0]  fmt_first;
    logic              free_any;
    logic [DIR_AW-1:0] free_slot;

    fba_link_ram u_link (
        .i_clk  (i_clk),
        .i_req  (link_req),
        .o_rdata(link_rdata)
    );

    fba_dir_ram u_dir (
        .i_clk  (i_clk),
        .i_req  (dir_req),
        .o_rdata(dir_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tuser   = r_out_status;
    assign o_m_tdata   = {1'b0, r_out_block};

    // A first data block below two is raised to two.
    assign fmt_first = (r_cfg < MIN_FIRST) ? MIN_FIRST : r_cfg;

    // Lowest invalid directory entry, used by create.
    always_comb begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int k = ROOT_ENTRIES - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_any  = 1'b1;
                free_slot = DIR_AW'(k);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_name       = r_name;
        n_idx        = r_idx;
        n_hit        = r_hit;
        n_eidx       = r_eidx;
        n_efirst     = r_efirst;
        n_faddr      = r_faddr;
        n_free_head  = r_free_head;
        n_valid      = r_valid;
        n_alloc      = r_alloc;
        n_cur        = r_cur;
        n_steps      = r_steps;
        n_status     = r_status;
        n_block      = r_block;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_block  = r_out_block;

        link_req       = '0;
        link_req.raddr = r_cur;
        dir_req        = '0;
        dir_req.raddr  = r_idx;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_req    = i_s_tuser;
                    n_name   = i_s_tdata;
                    n_idx    = '0;
                    n_hit    = 1'b0;
                    n_status = ST_OK;
                    n_block  = '0;
                    n_faddr  = '0;
                    case (i_s_tuser)
                        REQ_FORMAT: n_state = S_FMT;
                        REQ_CREATE, REQ_LOOKUP, REQ_ADD, REQ_REMOVE: n_state = S_SCAN;
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_FMT: begin
                // Entry zero mirrors the free head; blocks from the first data
                // block up link to their successor, the rest end a chain.
                link_req.we    = 1'b1;
                link_req.waddr = r_faddr;
                if (r_faddr == '0) begin
                    link_req.wdata = fmt_first;
                end else if (r_faddr >= fmt_first && r_faddr != LAST_BLOCK) begin
                    link_req.wdata = r_faddr + BLK_W'(1);
                end else begin
                    link_req.wdata = '0;
                end
                if (r_faddr == LAST_BLOCK) begin
                    n_free_head = fmt_first;
                    n_valid     = '0;
                    n_state     = S_RESP;
                end else begin
                    n_faddr = r_faddr + BLK_W'(1);
                end
            end
            S_SCAN: begin
                n_state = S_SCAN_D;
            end
            S_SCAN_D: begin
                if (!r_hit && r_valid[r_idx] && dir_rdata.name == r_name) begin
                    n_hit    = 1'b1;
                    n_eidx   = r_idx;
                    n_efirst = dir_rdata.first;
                end
                if (r_idx == LAST_ENTRY) begin
                    n_state = S_EXEC;
                end else begin
                    n_idx   = r_idx + DIR_AW'(1);
                    n_state = S_SCAN;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                case (r_req)
                    REQ_CREATE: begin
                        if (r_hit) begin
                            n_status = ST_EXISTS;
                        end else if (!free_any) begin
                            n_status = ST_FULL;
                        end else begin
                            dir_req.we          = 1'b1;
                            dir_req.waddr       = free_slot;
                            dir_req.wdata.name  = r_name;
                            dir_req.wdata.first = '0;
                            n_valid[free_slot]  = 1'b1;
                        end
                    end
                    REQ_LOOKUP: begin
                        if (r_hit) begin
                            n_block = r_efirst;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    REQ_ADD: begin
                        if (!r_hit) begin
                            n_status = ST_NOT_FOUND;
                        end else if (r_free_head == '0) begin
                            n_status = ST_NO_FREE;
                        end else begin
                            n_alloc = r_free_head;
                            n_cur   = r_free_head;
                            n_state = S_POP;
                        end
                    end
                    REQ_REMOVE: begin
                        if (!r_hit) begin
                            n_status = ST_NOT_FOUND;
                        end else if (r_efirst != '0) begin
                            n_status = ST_NOT_EMPTY;
                        end else begin
                            n_valid[r_eidx] = 1'b0;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_POP: begin
                n_state = S_POP_D;
            end
            S_POP_D: begin
                n_free_head    = link_rdata;
                link_req.we    = 1'b1;
                link_req.waddr = r_alloc;
                link_req.wdata = '0;
                n_block        = r_alloc;
                if (r_efirst == '0) begin
                    dir_req.we          = 1'b1;
                    dir_req.waddr       = r_eidx;
                    dir_req.wdata.name  = r_name;
                    dir_req.wdata.first = r_alloc;
                    n_state             = S_RESP;
                end else begin
                    n_cur   = r_efirst;
                    n_steps = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                n_state = S_WALK_D;
            end
            S_WALK_D: begin
                // Follow links until a chain end, or give up on a loop.
                if (link_rdata != '0 && r_steps < MAX_STEPS) begin
                    n_cur   = link_rdata;
                    n_steps = r_steps + STEP_W'(1);
                    n_state = S_WALK;
                end else begin
                    link_req.we    = 1'b1;
                    link_req.waddr = r_cur;
                    link_req.wdata = r_alloc;
                    n_state        = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_block  = r_block;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET;
            r_free_head <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_steps     <= '0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_steps     <= n_steps;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data[BLK_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_name       <= n_name;
        r_idx        <= n_idx;
        r_hit        <= n_hit;
        r_eidx       <= n_eidx;
        r_efirst     <= n_efirst;
        r_faddr      <= n_faddr;
        r_alloc      <= n_alloc;
        r_cur        <= n_cur;
        r_status     <= n_status;
        r_block      <= n_block;
        r_out_status <= n_out_status;
        r_out_block  <= n_out_block;
    end

    // A nonzero free head is never a reserved block.
    a_free_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_head == '0 || r_free_head >= MIN_FIRST)
        else $error("free head points into reserved blocks");

    // The chain walk is bounded by the table size.
    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= MAX_STEPS)
        else $error("chain walk exceeded table size");

    // Neither the link table nor the directory is written while waiting for a request.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !link_req.we && !dir_req.we)
        else $error("memory write while idle");

    // A result is loaded only when the output register is free or draining.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RESP && r_out_valid && !i_m_tready |=> r_state == S_RESP)
        else $error("result left while output stalled");

endmodule
